// ----- src/longest_valid_paren_run_core_macros.svh -----
// Assertion macros shared by the longest valid paren run core.
// Depends on nothing; included by the modules that carry assertions.
`ifndef LONGEST_VALID_PAREN_RUN_CORE_MACROS_SVH
`define LONGEST_VALID_PAREN_RUN_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LVPR_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LVPR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/lvpr_pkg.sv -----
// Package for the longest valid paren run core: sizes, symbol codes and types.
// Depends on nothing; used by every module of the core.
`default_nettype none
package lvpr_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int POS_WIDTH   = 16;
    localparam int CNT_WIDTH   = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_WIDTH  = $clog2(STACK_DEPTH);
    localparam int OUT_WIDTH   = 16;

    localparam logic [7:0] SYM_OPEN  = 8'd40;
    localparam logic [7:0] SYM_CLOSE = 8'd41;

    typedef logic [POS_WIDTH-1:0] pos_t;
    typedef logic [CNT_WIDTH-1:0] cnt_t;
    typedef logic [ADDR_WIDTH-1:0] addr_t;
    typedef logic [OUT_WIDTH-1:0] out_field_t;

    localparam pos_t POS_LIMIT = {POS_WIDTH{1'b1}};
    localparam cnt_t CNT_FULL  = CNT_WIDTH'(STACK_DEPTH);

    typedef struct packed {
        logic is_open;
        pos_t pos;
    } entry_t;

    typedef struct packed {
        logic   push;
        logic   pop;
        logic   clear;
        entry_t entry;
    } stack_cmd_t;

    typedef struct packed {
        cnt_t   count;
        entry_t top;
        entry_t second;
    } stack_stat_t;

    function automatic out_field_t to_out_field(input pos_t value);
        logic [47:0] wide;
        wide = 48'(value);
        return wide[OUT_WIDTH-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- src/lvpr_stack.sv -----
// Paren stack: a single-port-write, one-read synchronous memory with the top
// two entries cached in registers. Depends on lvpr_pkg and the macro header.
`default_nettype none
`include "longest_valid_paren_run_core_macros.svh"
module lvpr_stack
    import lvpr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire stack_cmd_t  cmd,
    output stack_stat_t      stat
);

    entry_t mem [STACK_DEPTH];

    cnt_t   count_reg;
    cnt_t   count_next;
    entry_t top_reg;
    entry_t top_next;
    entry_t second_reg;
    entry_t second_next;
    entry_t rd_data_reg;
    cnt_t   rd_index;
    addr_t  rd_addr;
    addr_t  wr_addr;

    // The prefetch read always fetches the entry two below the new top, so
    // that a pop can refill the second cache register in the next cycle.
    always_comb begin
        count_next  = count_reg;
        top_next    = top_reg;
        second_next = second_reg;
        if (cmd.push) begin
            count_next  = count_reg + cnt_t'(1);
            top_next    = cmd.entry;
            second_next = top_reg;
        end else if (cmd.pop) begin
            count_next  = count_reg - cnt_t'(1);
            top_next    = second_reg;
            second_next = rd_data_reg;
        end
        if (cmd.clear) begin
            count_next = '0;
        end
    end

    assign rd_index = count_next - cnt_t'(3);
    assign rd_addr  = rd_index[ADDR_WIDTH-1:0];
    assign wr_addr  = count_reg[ADDR_WIDTH-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            mem[wr_addr] <= cmd.entry;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg    <= top_next;
        second_reg <= second_next;
    end

    assign stat.count  = count_reg;
    assign stat.top    = top_reg;
    assign stat.second = second_reg;

    `LVPR_ASSERT_SAME(a_push_not_full, aclk, aresetn, cmd.push, count_reg != CNT_FULL, "push into a full stack")
    `LVPR_ASSERT_SAME(a_pop_not_empty, aclk, aresetn, cmd.pop, count_reg != '0, "pop from an empty stack")
    `LVPR_ASSERT_SAME(a_one_op, aclk, aresetn, cmd.push, !cmd.pop, "push and pop in one cycle")
    `LVPR_ASSERT_NEXT(a_push_top, aclk, aresetn, cmd.push && !cmd.clear, top_reg == $past(cmd.entry), "pushed entry not on top")
    `LVPR_ASSERT_NEXT(a_pop_count, aclk, aresetn, cmd.pop && !cmd.clear, count_reg == $past(count_reg) - cnt_t'(1), "pop did not lower the count")

endmodule
`default_nettype wire

// ----- src/lvpr_tracker.sv -----
// Match logic: decides push or pop per byte, tracks position, the longest run
// and overflow, and holds the result register. Depends on lvpr_pkg.
`default_nettype none
module lvpr_tracker
    import lvpr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,
    output logic             m_tuser,
    input  wire stack_stat_t stat,
    output stack_cmd_t       cmd
);

    pos_t pos_reg;
    pos_t pos_next;
    pos_t long_start_reg;
    pos_t long_start_next;
    pos_t long_len_reg;
    pos_t long_len_next;
    logic ovf_reg;
    logic ovf_next;
    logic m_valid_reg;
    logic m_valid_next;
    logic [31:0] m_data_reg;
    logic m_ovf_reg;

    logic accept;
    logic pos_full;
    logic is_open;
    logic is_close;
    logic top_open;
    logic stack_full;
    logic want_push;
    logic do_pop;
    pos_t run_start;
    pos_t run_len;

    assign s_tready = !m_valid_reg || m_tready || !s_tlast;
    assign accept   = s_tvalid && s_tready;

    assign pos_full   = pos_reg == POS_LIMIT;
    assign is_open    = s_tdata == SYM_OPEN;
    assign is_close   = s_tdata == SYM_CLOSE;
    assign top_open   = (stat.count != '0) && stat.top.is_open;
    assign stack_full = stat.count == CNT_FULL;

    assign do_pop    = accept && !pos_full && is_close && top_open;
    assign want_push = accept && !pos_full && (is_open || (is_close && !top_open));

    assign run_start = (stat.count == cnt_t'(1)) ? '0 : stat.second.pos + pos_t'(1);
    assign run_len   = pos_reg + pos_t'(1) - run_start;

    always_comb begin
        cmd.push         = want_push && !stack_full;
        cmd.pop          = do_pop;
        cmd.clear        = accept && s_tlast;
        cmd.entry.is_open = is_open;
        cmd.entry.pos    = pos_reg;
    end

    always_comb begin
        pos_next        = pos_reg;
        long_start_next = long_start_reg;
        long_len_next   = long_len_reg;
        ovf_next        = ovf_reg;
        if (accept) begin
            if (pos_full) begin
                ovf_next = 1'b1;
            end else begin
                pos_next = pos_reg + pos_t'(1);
                if (want_push && stack_full) begin
                    ovf_next = 1'b1;
                end
                if (do_pop && (run_len >= long_len_reg)) begin
                    long_start_next = run_start;
                    long_len_next   = run_len;
                end
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        if (accept && s_tlast) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            long_start_reg <= '0;
            long_len_reg   <= '0;
            ovf_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept && s_tlast) begin
                pos_reg        <= '0;
                long_start_reg <= '0;
                long_len_reg   <= '0;
                ovf_reg        <= 1'b0;
            end else begin
                pos_reg        <= pos_next;
                long_start_reg <= long_start_next;
                long_len_reg   <= long_len_next;
                ovf_reg        <= ovf_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_tlast) begin
            m_data_reg <= {to_out_field(long_len_next), to_out_field(long_start_next)};
            m_ovf_reg  <= ovf_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_ovf_reg;

endmodule
`default_nettype wire

// ----- src/longest_valid_paren_run_core.sv -----
// Top level of the longest valid paren run core: the match logic and the
// paren stack memory. Depends on lvpr_pkg, lvpr_tracker and lvpr_stack.
//
//   Channel  Direction  tdata                         tuser      tlast
//   s_       in         [7:0] symbol                  -          last byte
//   m_       out        [15:0] best_start,            overflow   -
//                       [31:16] best_length
//
// One byte is taken every cycle unless an untaken result holds back the last
// byte; the stack top and second entry sit in registers and the memory
// prefetches the third, so a pop needs no wait. A result appears in the cycle
// after the last byte is taken. Reset is synchronous, active low, and needs no
// clearing pass. A pending result that is not taken holds the input side only
// once a further request would overwrite it.
`default_nettype none
module longest_valid_paren_run_core
    import lvpr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] symbol
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [15:0] best_start, [31:16] best_length
    output logic             m_tuser    // [0] overflow
);

    stack_cmd_t  cmd;
    stack_stat_t stat;

    lvpr_tracker u_tracker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    lvpr_stack u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule
`default_nettype wire
